// File: design/gbe_pkg.sv
`default_nettype none
package gbe_pkg;

  localparam int MAX_CELLS_DEF = 64;
  localparam int IDX_W  = 7;
  localparam int IDX_MAX = (1 << IDX_W) - 1;
  localparam int SAMP_W = 16;
  localparam int FRAC_W = 17;
  localparam int Q_BITS = 16;
  localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(1 << Q_BITS);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_ADDR,
    S_MUL,
    S_ACC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       write_take;
    logic       query_take;
    logic       locate;
    logic       issue;
    logic       mul;
    logic       acc;
    logic       load_out;
    logic [1:0] corner;
  } ctrl_t;

endpackage
`default_nettype wire

// File: design/gbe_ram.sv
`default_nettype none
module gbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4225
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/gbe_ctrl.sv
`default_nettype none
module gbe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_command,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      gbe_pkg::ctrl_t cmd
);

  gbe_pkg::state_t state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbe_pkg::S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign load = (state_r == gbe_pkg::S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      gbe_pkg::S_IDLE: begin
        if (in_valid && in_command == gbe_pkg::CMD_QUERY) begin
          state_nxt = gbe_pkg::S_LOCATE;
        end
      end
      gbe_pkg::S_LOCATE: begin
        state_nxt = gbe_pkg::S_ADDR;
        k_nxt     = '0;
      end
      gbe_pkg::S_ADDR: state_nxt = gbe_pkg::S_MUL;
      gbe_pkg::S_MUL:  state_nxt = gbe_pkg::S_ACC;
      gbe_pkg::S_ACC: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = gbe_pkg::S_FIN;
        end else begin
          state_nxt = gbe_pkg::S_ADDR;
        end
      end
      gbe_pkg::S_FIN: begin
        if (load) begin
          state_nxt = gbe_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.corner     = k_r;
    cmd.load_out   = load;
    case (state_r)
      gbe_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        cmd.write_take = in_valid && (in_command == gbe_pkg::CMD_WRITE);
        cmd.query_take = in_valid && (in_command == gbe_pkg::CMD_QUERY);
      end
      gbe_pkg::S_LOCATE: cmd.locate = 1'b1;
      gbe_pkg::S_ADDR:   cmd.issue  = 1'b1;
      gbe_pkg::S_MUL:    cmd.mul    = 1'b1;
      gbe_pkg::S_ACC:    cmd.acc    = 1'b1;
      gbe_pkg::S_FIN:    in_ready   = 1'b0;
      default:           in_ready   = 1'b0;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: design/gbe_dp.sv
`default_nettype none
module gbe_dp #(
  parameter int MAX_CELLS = gbe_pkg::MAX_CELLS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire gbe_pkg::ctrl_t                   cmd,
  input  wire logic [gbe_pkg::IDX_W-1:0]        in_grid_x,
  input  wire logic [gbe_pkg::IDX_W-1:0]        in_grid_y,
  input  wire logic signed [gbe_pkg::SAMP_W-1:0] in_sample_value,
  input  wire logic [gbe_pkg::FRAC_W-1:0]       in_lon_frac,
  input  wire logic [gbe_pkg::FRAC_W-1:0]       in_lat_frac,
  input  wire logic                             cfg_we,
  input  wire logic [gbe_pkg::IDX_W-1:0]        cfg_data,
  output      logic signed [gbe_pkg::SAMP_W-1:0] out_elevation
);

  localparam int IW = gbe_pkg::IDX_W;
  localparam int FW = gbe_pkg::FRAC_W;
  localparam int SW = gbe_pkg::SAMP_W;
  localparam int QB = gbe_pkg::Q_BITS;
  localparam int GRID_SIDE  = MAX_CELLS + 1;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(GRID_DEPTH);
  localparam int W_W = 2 * QB + 1;
  localparam int ACC_W = W_W + 1 + SW;
  localparam logic [IW-1:0] N_CAP =
    IW'((MAX_CELLS > gbe_pkg::IDX_MAX) ? gbe_pkg::IDX_MAX : MAX_CELLS);

  function automatic logic [IW+FW-1:0] locate(input logic [FW-1:0] f,
                                               input logic [IW-1:0] n);
    logic [FW+IW-1:0] scaled;
    logic [IW-1:0]    c;
    scaled = f * n;
    c = scaled[QB +: IW];
    if (c >= n) begin
      c = n - 1'b1;
    end
    return {c, FW'(scaled - (FW+IW)'({c, {QB{1'b0}}}))};
  endfunction

  logic [IW-1:0]          cells_r;
  logic [IW-1:0]          n_eff;
  logic [FW-1:0]          lon_r, lat_r;
  logic [IW-1:0]          cx_r, cy_r;
  logic [FW-1:0]          tx_r, ty_r;
  logic [FW-1:0]          ux, uy, wx, wy;
  logic [W_W-1:0]         w_r;
  logic signed [ACC_W-1:0] prod_r, acc_r, biased;
  logic signed [SW-1:0]   out_r;
  logic [IW:0]            xa, ya;
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [SW-1:0]          rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= N_CAP;
    end else if (cfg_we) begin
      cells_r <= cfg_data;
    end
  end

  assign n_eff = (cells_r == '0) ? IW'(1) : ((cells_r > N_CAP) ? N_CAP : cells_r);

  assign we = cmd.write_take && (32'(in_grid_x) <= 32'(MAX_CELLS))
           && (32'(in_grid_y) <= 32'(MAX_CELLS));
  assign waddr = AW'(AW'(in_grid_y) * AW'(GRID_SIDE) + AW'(in_grid_x));

  assign ux = gbe_pkg::Q16_ONE - tx_r;
  assign uy = gbe_pkg::Q16_ONE - ty_r;
  assign wx = cmd.corner[0] ? tx_r : ux;
  assign wy = cmd.corner[1] ? ty_r : uy;
  assign xa = {1'b0, cx_r} + (IW+1)'(cmd.corner[0]);
  assign ya = {1'b0, cy_r} + (IW+1)'(cmd.corner[1]);
  assign raddr = AW'(AW'(ya) * AW'(GRID_SIDE) + AW'(xa));

  assign biased = acc_r + (acc_r[ACC_W-1] ? ACC_W'((64'd1 << (2 * QB)) - 64'd1) : '0);

  always_ff @(posedge clk) begin
    if (cmd.query_take) begin
      lon_r <= (in_lon_frac > gbe_pkg::Q16_ONE) ? gbe_pkg::Q16_ONE : in_lon_frac;
      lat_r <= (in_lat_frac > gbe_pkg::Q16_ONE) ? gbe_pkg::Q16_ONE : in_lat_frac;
    end
    if (cmd.locate) begin
      {cx_r, tx_r} <= locate(lon_r, n_eff);
      {cy_r, ty_r} <= locate(lat_r, n_eff);
      acc_r        <= '0;
    end
    if (cmd.issue) begin
      w_r <= W_W'(wx) * W_W'(wy);
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, w_r}) * $signed(rdata);
    end
    if (cmd.acc) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.load_out) begin
      out_r <= biased[2 * QB +: SW];
    end
  end

  gbe_ram #(
    .WIDTH(SW),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_sample_value),
    .re   (cmd.issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_elevation = out_r;

endmodule
`default_nettype wire

// File: design/grid_bilinear_elevation_core.sv
// Bilinear elevation lookup over a square grid of (n+1) x (n+1) signed 16-bit
// samples held in one single-port-read RAM. A write beat stores one sample; a
// beat whose index lies outside the grid is dropped. A query beat runs through
// these steps from acceptance until the next beat can be taken: locate the
// cell, then address, multiply and accumulate for each corner in turn, because
// the four corners are fetched one at a time through the RAM's single
// registered read port, then truncate the sum toward zero and load the result
// register, then return to idle, where the next beat is taken. A finished
// result waits in that register, and a new beat is accepted while it waits; a
// later query that finishes while the register is still full holds in its last
// step until the waiting beat is taken. The resolution register may be written
// only while no query is in flight; its write channel is always ready.
`default_nettype none
module grid_bilinear_elevation_core #(
  parameter int MAX_CELLS = gbe_pkg::MAX_CELLS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic                              in_command,
  input  wire logic [gbe_pkg::IDX_W-1:0]         in_grid_x,
  input  wire logic [gbe_pkg::IDX_W-1:0]         in_grid_y,
  input  wire logic signed [gbe_pkg::SAMP_W-1:0] in_sample_value,
  input  wire logic [gbe_pkg::FRAC_W-1:0]        in_lon_frac,
  input  wire logic [gbe_pkg::FRAC_W-1:0]        in_lat_frac,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic signed [gbe_pkg::SAMP_W-1:0] out_elevation,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [gbe_pkg::IDX_W-1:0]         cfg_data
);

  gbe_pkg::ctrl_t cmd;

  assign cfg_ready = 1'b1;

  gbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gbe_dp #(
    .MAX_CELLS(MAX_CELLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_grid_x      (in_grid_x),
    .in_grid_y      (in_grid_y),
    .in_sample_value(in_sample_value),
    .in_lon_frac    (in_lon_frac),
    .in_lat_frac    (in_lat_frac),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .out_elevation  (out_elevation)
  );

`ifndef SYNTHESIS
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == gbe_pkg::CMD_QUERY) |=> !in_ready)
    else $error("intake stayed open after a query beat");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == gbe_pkg::CMD_WRITE) |=> in_ready)
    else $error("write beat did not finish in one cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a query in flight");
`endif

endmodule
`default_nettype wire

// File: tb/tb_grid_bilinear_elevation_core.sv
`default_nettype none
module tb_grid_bilinear_elevation_core;
  import gbe_pkg::*;

  localparam int GRID_MAX  = MAX_CELLS_DEF;
  localparam int GRID_SIDE = GRID_MAX + 1;
  localparam int GRID_SIZE = GRID_SIDE * GRID_SIDE;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 100;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 105;

  typedef struct {
    logic                     cmd;
    logic [IDX_W-1:0]         x;
    logic [IDX_W-1:0]         y;
    logic signed [SAMP_W-1:0] val;
    logic [FRAC_W-1:0]        lon;
    logic [FRAC_W-1:0]        lat;
  } grid_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_WRITE;
  logic [IDX_W-1:0] in_grid_x = '0;
  logic [IDX_W-1:0] in_grid_y = '0;
  logic signed [SAMP_W-1:0] in_sample_value = '0;
  logic [FRAC_W-1:0] in_lon_frac = '0;
  logic [FRAC_W-1:0] in_lat_frac = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMP_W-1:0] out_elevation;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_data = '0;

  grid_beat_t beat_queue[$];
  grid_beat_t cur_beat;
  logic signed [SAMP_W-1:0] elev_expect[$];
  logic signed [SAMP_W-1:0] want_elev;
  logic signed [SAMP_W-1:0] grid_shadow [0:GRID_SIZE-1];
  bit grid_loaded [0:GRID_SIZE-1];
  logic [IDX_W-1:0] cells_reg = IDX_W'(GRID_MAX);
  logic [IDX_W-1:0] gen_cells = IDX_W'(GRID_MAX);

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int queued_items = 0;
  int writes_taken = 0;
  int queries_taken = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned cycle_count = 0;

  grid_bilinear_elevation_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_grid_x       (in_grid_x),
    .in_grid_y       (in_grid_y),
    .in_sample_value (in_sample_value),
    .in_lon_frac     (in_lon_frac),
    .in_lat_frac     (in_lat_frac),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_elevation   (out_elevation),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_cells(logic [IDX_W-1:0] r);
    if (r == 0) return 1;
    if (r > GRID_MAX) return GRID_MAX;
    return r;
  endfunction

  function automatic void locate_cell(input logic [FRAC_W-1:0] frac, input int unsigned n,
                                      output int unsigned cell_idx, output longint t);
    longint f;
    longint scaled;
    longint c;
    f = (frac > Q16_ONE) ? longint'(Q16_ONE) : longint'(frac);
    scaled = f * longint'(n);
    c = scaled >>> Q_BITS;
    if (c >= n) c = n - 1;
    cell_idx = c;
    t = scaled - (c <<< Q_BITS);
  endfunction

  function automatic longint sample_at(int unsigned x, int unsigned y);
    return longint'(grid_shadow[y * GRID_SIDE + x]);
  endfunction

  function automatic logic signed [SAMP_W-1:0] predict_elevation(logic [FRAC_W-1:0] lon,
                                                                 logic [FRAC_W-1:0] lat);
    int unsigned n;
    int unsigned cx;
    int unsigned cy;
    longint tx;
    longint ty;
    longint ux;
    longint uy;
    longint acc;
    n = eff_cells(cells_reg);
    locate_cell(lon, n, cx, tx);
    locate_cell(lat, n, cy, ty);
    ux = 65536 - tx;
    uy = 65536 - ty;
    acc = ux * uy * sample_at(cx, cy);
    acc += tx * uy * sample_at(cx + 1, cy);
    acc += ux * ty * sample_at(cx, cy + 1);
    acc += tx * ty * sample_at(cx + 1, cy + 1);
    return SAMP_W'(acc / 64'sd4294967296);
  endfunction

  task automatic apply_beat(grid_beat_t b);
    if (b.cmd == CMD_WRITE) begin
      if (b.x <= GRID_MAX && b.y <= GRID_MAX) grid_shadow[b.y * GRID_SIDE + b.x] = b.val;
      writes_taken++;
    end else begin
      elev_expect.push_back(predict_elevation(b.lon, b.lat));
      queries_taken++;
    end
  endtask

  task automatic report_mismatch(string what, logic signed [SAMP_W-1:0] want,
                                 logic signed [SAMP_W-1:0] got);
    $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
    errors++;
  endtask

  task automatic add_write(int x, int y, logic signed [SAMP_W-1:0] v);
    grid_beat_t b;
    b.cmd = CMD_WRITE;
    b.x = IDX_W'(x);
    b.y = IDX_W'(y);
    b.val = v;
    b.lon = FRAC_W'($urandom_range(131071));
    b.lat = FRAC_W'($urandom_range(131071));
    if (x <= GRID_MAX && y <= GRID_MAX) grid_loaded[y * GRID_SIDE + x] = 1'b1;
    beat_queue.push_back(b);
    queued_items++;
  endtask

  // Any corner the query touches that was never written is filled first.
  task automatic add_query(logic [FRAC_W-1:0] lon, logic [FRAC_W-1:0] lat);
    grid_beat_t b;
    int unsigned n;
    int unsigned cx;
    int unsigned cy;
    longint tx;
    longint ty;
    n = eff_cells(gen_cells);
    locate_cell(lon, n, cx, tx);
    locate_cell(lat, n, cy, ty);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (!grid_loaded[(cy + dy) * GRID_SIDE + cx + dx])
          add_write(cx + dx, cy + dy, SAMP_W'($urandom_range(65535)));
      end
    end
    b.cmd = CMD_QUERY;
    b.x = IDX_W'($urandom_range(127));
    b.y = IDX_W'($urandom_range(127));
    b.val = SAMP_W'($urandom_range(65535));
    b.lon = lon;
    b.lat = lat;
    beat_queue.push_back(b);
    queued_items++;
  endtask

  function automatic logic [FRAC_W-1:0] pick_frac(int unsigned n);
    case ($urandom_range(9))
      0: return '0;
      1: return Q16_ONE;
      2: return FRAC_W'($urandom_range(131071, 65537));
      3: return FRAC_W'((65536 * $urandom_range(n)) / n);
      default: return FRAC_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic add_random_item();
    int unsigned n;
    int sel;
    n = eff_cells(gen_cells);
    sel = $urandom_range(99);
    if (sel < 55) begin
      add_query(pick_frac(n), pick_frac(n));
    end else if (sel < 75) begin
      add_write($urandom_range(n), $urandom_range(n), SAMP_W'($urandom_range(65535)));
    end else if (sel < 90) begin
      add_write($urandom_range(GRID_MAX), $urandom_range(GRID_MAX),
                SAMP_W'($urandom_range(65535)));
    end else if (sel < 95) begin
      add_write($urandom_range(127, GRID_MAX + 1), $urandom_range(127),
                SAMP_W'($urandom_range(65535)));
    end else begin
      add_write($urandom_range(GRID_MAX), $urandom_range(127, GRID_MAX + 1),
                SAMP_W'($urandom_range(65535)));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beat_queue.size() != 0 || in_valid || elev_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cells(logic [IDX_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cells_reg = v;
    gen_cells = v;
    cfg_writes++;
  endtask

  task automatic add_directed();
    add_write(0, 0, 16'sd32767);
    add_write(1, 0, 16'sd32767);
    add_write(0, 1, 16'sd32767);
    add_write(1, 1, 16'sd32767);
    add_query(0, 0);
    add_write(64, 64, -16'sd32768);
    add_write(63, 64, -16'sd32768);
    add_write(64, 63, -16'sd32768);
    add_write(63, 63, -16'sd32768);
    add_query(65536, 65536);
    add_query(131071, 131071);
    add_write(65, 3, 16'sd123);
    add_write(5, 127, -16'sd5);
    add_write(127, 127, -16'sd1);
    add_write(10, 10, -16'sd3);
    add_write(11, 10, 16'sd0);
    add_write(10, 11, 16'sd0);
    add_write(11, 11, 16'sd0);
    add_query(10752, 10240);
    add_query(32768, 32768);
    add_query(1024, 65535);
    add_query(65536, 0);
    add_query(0, 65536);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, elev_expect.size());
      $display("grid_bilinear_elevation_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_beat(cur_beat);
      if (!in_valid || in_ready) begin
        if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = beat_queue.pop_front();
          in_valid <= 1'b1;
          in_command <= cur_beat.cmd;
          in_grid_x <= cur_beat.x;
          in_grid_y <= cur_beat.y;
          in_sample_value <= cur_beat.val;
          in_lon_frac <= cur_beat.lon;
          in_lat_frac <= cur_beat.lat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver stall fills the result register and holds a later query in its last step.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (elev_expect.size() == 0) begin
          report_mismatch("result beat with nothing expected", 'x, out_elevation);
        end else begin
          want_elev = elev_expect.pop_front();
          if (out_elevation !== want_elev) report_mismatch("elevation", want_elev, out_elevation);
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [IDX_W-1:0] cfg_plan [1:NUM_PHASES-1];
    int phase_start;
    cfg_plan = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd5, 7'd65, 7'd33, 7'd2};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 74;
      end else if (p < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p != 0) begin
        write_cells(cfg_plan[p]);
        @(negedge clk);
      end
      phase_start = queued_items;
      if (p == 0) add_directed();
      while (queued_items - phase_start < PHASE_ITEMS) add_random_item();
      wait_drained();
    end
    $display("Ran %0d grid writes and %0d elevation queries over %0d resolution settings.",
             writes_taken, queries_taken, cfg_writes + 1);
    $display("Checked %0d result beats, including a %0d-cycle receiver stall.",
             results_seen, HOLD_CYCLES);
    if (errors == 0) begin
      $display("grid_bilinear_elevation_core test passed");
    end else begin
      $display("grid_bilinear_elevation_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
design/gbe_pkg.sv
design/gbe_ram.sv
design/gbe_ctrl.sv
design/gbe_dp.sv
design/grid_bilinear_elevation_core.sv
tb/tb_grid_bilinear_elevation_core.sv
